@@ src/rgb_pixel_pulse_encoder_unit_macros.svh @@
// Assertion macros for the pixel pulse encoder.
`ifndef RGB_PIXEL_PULSE_ENCODER_UNIT_MACROS_SVH
`define RGB_PIXEL_PULSE_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PPE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define PPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ppe_pkg.sv @@
// Shared types, constants and helpers for the pixel pulse encoder.
package ppe_pkg;

    localparam int TICK_WIDTH = 15;
    localparam int PIXEL_BITS = 24;
    localparam int BITS_W     = 5;
    localparam int FRAME_W    = 32;
    localparam int CFG_IDX_W  = 3;

    typedef logic [TICK_WIDTH-1:0] t_tick;

    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_HALF  = 3'd4;

    localparam t_tick RST_ONE_HIGH  = t_tick'(14);
    localparam t_tick RST_ONE_LOW   = t_tick'(11);
    localparam t_tick RST_ZERO_HIGH = t_tick'(7);
    localparam t_tick RST_ZERO_LOW  = t_tick'(18);
    localparam t_tick RST_GAP_HALF  = t_tick'(1000);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HIGH  = 3'd1,
        PH_LOW   = 3'd2,
        PH_GAP_A = 3'd3,
        PH_GAP_B = 3'd4
    } t_phase;

    typedef struct packed {
        t_tick one_high;
        t_tick one_low;
        t_tick zero_high;
        t_tick zero_low;
        t_tick gap_half;
    } t_cfg;

    typedef struct packed {
        logic               line_level;
        logic               busy;
        logic               frame_done;
        logic               start_ignored;
        logic [FRAME_W-1:0] frames_sent;
    } t_result;

    // A zero duration still lasts one tick.
    function automatic t_tick dur(input t_tick v);
        return (v == '0) ? t_tick'(1) : v;
    endfunction

endpackage

@@ src/ppe_cfg_regs.sv @@
// Timing configuration registers of the pixel pulse encoder.
module ppe_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [ppe_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  ppe_pkg::t_tick                  i_wr_data,
    output ppe_pkg::t_cfg                   o_cfg
);

    ppe_pkg::t_cfg r_cfg;
    ppe_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                ppe_pkg::REG_ONE_HIGH:  n_cfg.one_high  = i_wr_data;
                ppe_pkg::REG_ONE_LOW:   n_cfg.one_low   = i_wr_data;
                ppe_pkg::REG_ZERO_HIGH: n_cfg.zero_high = i_wr_data;
                ppe_pkg::REG_ZERO_LOW:  n_cfg.zero_low  = i_wr_data;
                ppe_pkg::REG_GAP_HALF:  n_cfg.gap_half  = i_wr_data;
                default:                n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_high  <= ppe_pkg::RST_ONE_HIGH;
            r_cfg.one_low   <= ppe_pkg::RST_ONE_LOW;
            r_cfg.zero_high <= ppe_pkg::RST_ZERO_HIGH;
            r_cfg.zero_low  <= ppe_pkg::RST_ZERO_LOW;
            r_cfg.gap_half  <= ppe_pkg::RST_GAP_HALF;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/ppe_core.sv @@
// Bit and gap sequencer: frame state and per-tick result logic.
module ppe_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_cmd,
    input  logic [7:0]      i_red,
    input  logic [7:0]      i_green,
    input  logic [7:0]      i_blue,
    input  ppe_pkg::t_cfg   i_cfg,
    output ppe_pkg::t_result o_res
);

    ppe_pkg::t_phase                    r_phase, n_phase, e_phase;
    ppe_pkg::t_tick                     r_ticks, n_ticks, e_ticks, dec_ticks;
    logic [ppe_pkg::PIXEL_BITS-1:0]     r_shift, n_shift, e_shift, shift_sh;
    logic [ppe_pkg::BITS_W-1:0]         r_bits, n_bits, e_bits, bits_dec;
    logic [ppe_pkg::FRAME_W-1:0]        r_frames, n_frames;
    logic                               start_ok;
    logic                               phase_end;

    // A start on an idle line loads the pixel and counts as the first tick.
    always_comb begin
        start_ok  = i_cmd && (r_phase == ppe_pkg::PH_IDLE);
        e_phase   = start_ok ? ppe_pkg::PH_HIGH : r_phase;
        e_shift   = start_ok ? {i_green, i_red, i_blue} : r_shift;
        e_bits    = start_ok ? ppe_pkg::BITS_W'(ppe_pkg::PIXEL_BITS) : r_bits;
        e_ticks   = start_ok ? ppe_pkg::dur(i_green[7] ? i_cfg.one_high : i_cfg.zero_high)
                             : r_ticks;
        dec_ticks = (e_ticks != '0) ? e_ticks - ppe_pkg::t_tick'(1) : '0;
        bits_dec  = (e_bits != '0) ? e_bits - ppe_pkg::BITS_W'(1) : '0;
        shift_sh  = {e_shift[ppe_pkg::PIXEL_BITS-2:0], 1'b0};
        phase_end = (e_phase != ppe_pkg::PH_IDLE) && (dec_ticks == '0);
    end

    // Next state
    always_comb begin
        n_phase  = e_phase;
        n_shift  = e_shift;
        n_bits   = e_bits;
        n_frames = r_frames;
        n_ticks  = (e_phase != ppe_pkg::PH_IDLE) ? dec_ticks : e_ticks;
        if (phase_end) begin
            unique case (e_phase)
                ppe_pkg::PH_HIGH: begin
                    n_phase = ppe_pkg::PH_LOW;
                    n_ticks = ppe_pkg::dur(e_shift[ppe_pkg::PIXEL_BITS-1] ? i_cfg.one_low
                                                                          : i_cfg.zero_low);
                end
                ppe_pkg::PH_LOW: begin
                    n_bits  = bits_dec;
                    n_shift = shift_sh;
                    if (bits_dec != '0) begin
                        n_phase = ppe_pkg::PH_HIGH;
                        n_ticks = ppe_pkg::dur(shift_sh[ppe_pkg::PIXEL_BITS-1]
                                               ? i_cfg.one_high : i_cfg.zero_high);
                    end else begin
                        n_phase = ppe_pkg::PH_GAP_A;
                        n_ticks = ppe_pkg::dur(i_cfg.gap_half);
                    end
                end
                ppe_pkg::PH_GAP_A: begin
                    n_phase = ppe_pkg::PH_GAP_B;
                    n_ticks = ppe_pkg::dur(i_cfg.gap_half);
                end
                default: begin
                    n_phase  = ppe_pkg::PH_IDLE;
                    n_ticks  = '0;
                    n_bits   = '0;
                    n_frames = r_frames + ppe_pkg::FRAME_W'(1);
                end
            endcase
        end
    end

    // Outputs for this tick
    always_comb begin
        o_res.busy          = (e_phase != ppe_pkg::PH_IDLE);
        o_res.line_level    = (e_phase == ppe_pkg::PH_HIGH);
        o_res.frame_done    = phase_end && (e_phase != ppe_pkg::PH_HIGH)
                              && (e_phase != ppe_pkg::PH_LOW)
                              && (e_phase != ppe_pkg::PH_GAP_A);
        o_res.start_ignored = i_cmd && (r_phase != ppe_pkg::PH_IDLE);
        o_res.frames_sent   = n_frames;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ppe_pkg::PH_IDLE;
            r_ticks  <= '0;
            r_shift  <= '0;
            r_bits   <= '0;
            r_frames <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_ticks  <= n_ticks;
            r_shift  <= n_shift;
            r_bits   <= n_bits;
            r_frames <= n_frames;
        end
    end

endmodule

@@ src/rgb_pixel_pulse_encoder_unit.sv @@
// Top level of the pixel pulse encoder: handshakes, config port, result register.
// Latency: the result of a transaction is valid in the cycle after it is accepted.
// Throughput: one transaction per cycle; the frame state updates in a single pass
// per tick, and the result register frees up as the consumer takes each result.
// Reset (synchronous, active low): line idle, no frame running, frame count zero,
// timing registers back to their defaults, result register empty.
`include "rgb_pixel_pulse_encoder_unit_macros.svh"

module rgb_pixel_pulse_encoder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [7:0]                      i_red,
    input  logic [7:0]                      i_green,
    input  logic [7:0]                      i_blue,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_line_level,
    output logic                            o_busy_res,
    output logic                            o_frame_done,
    output logic                            o_start_ignored,
    output logic [ppe_pkg::FRAME_W-1:0]     o_frames_sent,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ppe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  ppe_pkg::t_tick                  i_cfg_data
);

    ppe_pkg::t_cfg      cfg;
    ppe_pkg::t_result   res;
    ppe_pkg::t_result   r_res;
    logic               r_out_valid;
    logic               in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;

    ppe_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    ppe_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_cmd    (i_cmd),
        .i_red    (i_red),
        .i_green  (i_green),
        .i_blue   (i_blue),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    // Hold the result while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_line_level    = r_res.line_level;
    assign o_busy_res      = r_res.busy;
    assign o_frame_done    = r_res.frame_done;
    assign o_start_ignored = r_res.start_ignored;
    assign o_frames_sent   = r_res.frames_sent;

    `PPE_ASSERT_NEXT(a_accept_gives_result, in_accept, r_out_valid, "accepted transaction lost")
    `PPE_ASSERT_NOW(a_done_in_gap, r_out_valid && r_res.frame_done, r_res.busy && !r_res.line_level, "frame end outside the gap")
    `PPE_ASSERT_NOW(a_high_while_busy, r_out_valid && r_res.line_level, r_res.busy, "line high with no frame running")
    `PPE_ASSERT_NOW(a_ignore_while_busy, r_out_valid && r_res.start_ignored, r_res.busy, "start dropped on an idle line")

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the RGB pixel pulse encoder: directed table, extremes, random frames.
module testbench;

    localparam int          LONG_HOLD   = 40;
    localparam int          DRAIN_TAIL  = 8;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int          RAND_PHASES = 10;
    localparam int          PHASE_ITEMS = 150;
    localparam int          MAX_REPORTS = 50;
    localparam int          DIR_N       = 22;

    localparam logic [ppe_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [ppe_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
    localparam ppe_pkg::t_tick                SHORT_GAP       = ppe_pkg::t_tick'(20);

    typedef struct packed {
        logic             cmd;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             typed;
        ppe_pkg::t_result want;
    } t_row;

    // typed rows carry their own expectation, the rest go through the predictor
    localparam t_row DIR_ROWS [DIR_N] = '{
        // idle ticks: line low, nothing counted, pixel fields have no effect
        '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
        '{1'b0, 8'h00, 8'h00, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
        // start with green MSB set: line goes high on the start tick itself
        '{1'b1, 8'h00, 8'hFF, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 32'd0}},
        // start during a frame: dropped and flagged, still a tick
        '{1'b1, 8'hFF, 8'h00, 8'hFF, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 32'd0}},
        '{1'b0, 8'h55, 8'hAA, 8'h0F, 1'b0, '0},
        '{1'b0, 8'hAA, 8'h55, 8'hF0, 1'b0, '0},
        '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
        '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{1'b0, 8'h80, 8'h01, 8'h7E, 1'b0, '0},
        '{1'b0, 8'h01, 8'h80, 8'h81, 1'b0, '0},
        '{1'b0, 8'h3C, 8'hC3, 8'h5A, 1'b0, '0},
        '{1'b0, 8'hC3, 8'h3C, 8'hA5, 1'b0, '0},
        '{1'b0, 8'h12, 8'h34, 8'h56, 1'b0, '0},
        '{1'b0, 8'h78, 8'h9A, 8'hBC, 1'b0, '0},
        '{1'b0, 8'hDE, 8'hF0, 8'h01, 1'b0, '0},
        '{1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 32'd0}},
        '{1'b0, 8'h00, 8'hFF, 8'h00, 1'b0, '0},
        '{1'b0, 8'hFF, 8'h00, 8'hFF, 1'b0, '0},
        '{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{1'b0, 8'h0F, 8'hF0, 8'h0F, 1'b0, '0},
        '{1'b0, 8'hF0, 8'h0F, 8'hF0, 1'b0, '0},
        '{1'b0, 8'h99, 8'h66, 8'h99, 1'b0, '0}
    };

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic                          i_cmd;
    logic [7:0]                    i_red;
    logic [7:0]                    i_green;
    logic [7:0]                    i_blue;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic                          o_line_level;
    logic                          o_busy_res;
    logic                          o_frame_done;
    logic                          o_start_ignored;
    logic [ppe_pkg::FRAME_W-1:0]   o_frames_sent;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [ppe_pkg::CFG_IDX_W-1:0] i_cfg_index;
    ppe_pkg::t_tick                i_cfg_data;

    // encoder shadow state
    ppe_pkg::t_cfg                  timing;
    logic [ppe_pkg::PIXEL_BITS-1:0] pix_word;
    logic [ppe_pkg::BITS_W-1:0]     bits_left;
    ppe_pkg::t_phase                phase_now;
    ppe_pkg::t_tick                 phase_left;
    logic [ppe_pkg::FRAME_W-1:0]    frame_total;

    ppe_pkg::t_result pulse_q[$];
    int               mismatches  = 0;
    int unsigned      cycle_count = 0;
    bit               quiet       = 1'b0;
    bit               hold_req    = 1'b0;

    rgb_pixel_pulse_encoder_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_line_level    (o_line_level),
        .o_busy_res      (o_busy_res),
        .o_frame_done    (o_frame_done),
        .o_start_ignored (o_start_ignored),
        .o_frames_sent   (o_frames_sent),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic ppe_pkg::t_tick ticks_or_one(input ppe_pkg::t_tick v);
        return (v == '0) ? ppe_pkg::t_tick'(1) : v;
    endfunction

    // duration of the high or low part of the bit now at the MSB
    function automatic ppe_pkg::t_tick bit_part_ticks(input bit high_part);
        if (pix_word[ppe_pkg::PIXEL_BITS-1])
            return ticks_or_one(high_part ? timing.one_high : timing.one_low);
        return ticks_or_one(high_part ? timing.zero_high : timing.zero_low);
    endfunction

    function automatic ppe_pkg::t_result encode_tick(input logic cmd, input logic [7:0] red,
                                                     input logic [7:0] green,
                                                     input logic [7:0] blue);
        ppe_pkg::t_result res;
        res = '0;
        if (cmd) begin
            if (phase_now != ppe_pkg::PH_IDLE) begin
                res.start_ignored = 1'b1;
            end else begin
                pix_word   = {green, red, blue};
                bits_left  = ppe_pkg::BITS_W'(ppe_pkg::PIXEL_BITS);
                phase_now  = ppe_pkg::PH_HIGH;
                phase_left = bit_part_ticks(1'b1);
            end
        end
        if (phase_now != ppe_pkg::PH_IDLE) begin
            res.busy       = 1'b1;
            res.line_level = (phase_now == ppe_pkg::PH_HIGH);
            phase_left     = (phase_left > 0) ? phase_left - 1'b1 : '0;
            if (phase_left == '0) begin
                case (phase_now)
                    ppe_pkg::PH_HIGH: begin
                        phase_now  = ppe_pkg::PH_LOW;
                        phase_left = bit_part_ticks(1'b0);
                    end
                    ppe_pkg::PH_LOW: begin
                        bits_left = (bits_left > 0) ? bits_left - 1'b1 : '0;
                        pix_word  = pix_word << 1;
                        if (bits_left > 0) begin
                            phase_now  = ppe_pkg::PH_HIGH;
                            phase_left = bit_part_ticks(1'b1);
                        end else begin
                            phase_now  = ppe_pkg::PH_GAP_A;
                            phase_left = ticks_or_one(timing.gap_half);
                        end
                    end
                    ppe_pkg::PH_GAP_A: begin
                        phase_now  = ppe_pkg::PH_GAP_B;
                        phase_left = ticks_or_one(timing.gap_half);
                    end
                    default: begin
                        phase_now      = ppe_pkg::PH_IDLE;
                        phase_left     = '0;
                        bits_left      = '0;
                        frame_total    = frame_total + 1'b1;
                        res.frame_done = 1'b1;
                    end
                endcase
            end
        end
        res.frames_sent = frame_total;
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endfunction

    function automatic ppe_pkg::t_tick short_ticks();
        return ($urandom_range(0, 7) == 0) ? ppe_pkg::t_tick'(0)
                                            : ppe_pkg::t_tick'($urandom_range(1, 4));
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input bit typed = 1'b0,
                             input ppe_pkg::t_result want = '0);
        int               idle;
        ppe_pkg::t_result pred;
        idle = quiet ? 0 : $urandom_range(0, 7);
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_red      <= red;
        i_green    <= green;
        i_blue     <= blue;
        do @(posedge i_clk); while (!o_in_ready);
        pred = encode_tick(cmd, red, green, blue);
        pulse_q.push_back(typed ? want : pred);
    endtask

    // tick until the running frame, gap included, is over
    task automatic finish_frame();
        while (phase_now != ppe_pkg::PH_IDLE)
            send_item(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic write_reg(input logic [ppe_pkg::CFG_IDX_W-1:0] idx,
                             input ppe_pkg::t_tick val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ppe_pkg::REG_ONE_HIGH:  timing.one_high  = val;
            ppe_pkg::REG_ONE_LOW:   timing.one_low   = val;
            ppe_pkg::REG_ZERO_HIGH: timing.zero_high = val;
            ppe_pkg::REG_ZERO_LOW:  timing.zero_low  = val;
            ppe_pkg::REG_GAP_HALF:  timing.gap_half  = val;
            default: ;
        endcase
    endtask

    // drain outstanding results, then rewrite every timing register
    task automatic program_timing(input ppe_pkg::t_tick one_high, input ppe_pkg::t_tick one_low,
                                  input ppe_pkg::t_tick zero_high,
                                  input ppe_pkg::t_tick zero_low,
                                  input ppe_pkg::t_tick gap_half);
        i_in_valid <= 1'b0;
        wait (pulse_q.size() == 0);
        @(posedge i_clk);
        write_reg(ppe_pkg::REG_ONE_HIGH, one_high);
        write_reg(ppe_pkg::REG_ONE_LOW, one_low);
        write_reg(ppe_pkg::REG_ZERO_HIGH, zero_high);
        write_reg(ppe_pkg::REG_ZERO_LOW, zero_low);
        write_reg(ppe_pkg::REG_GAP_HALF, gap_half);
        // unmapped indexes must leave the timing alone
        for (int k = REG_SPARE_FIRST; k <= REG_SPARE_LAST; k++)
            write_reg(ppe_pkg::CFG_IDX_W'(k), ppe_pkg::t_tick'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic start;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_cmd       <= 1'b0;
        i_red       <= '0;
        i_green     <= '0;
        i_blue      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        timing      = '{ppe_pkg::RST_ONE_HIGH, ppe_pkg::RST_ONE_LOW, ppe_pkg::RST_ZERO_HIGH,
                        ppe_pkg::RST_ZERO_LOW, ppe_pkg::RST_GAP_HALF};
        pix_word    = '0;
        bits_left   = '0;
        phase_now   = ppe_pkg::PH_IDLE;
        phase_left  = '0;
        frame_total = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_N; k++)
            send_item(DIR_ROWS[k].cmd, DIR_ROWS[k].red, DIR_ROWS[k].green,
                      DIR_ROWS[k].blue, DIR_ROWS[k].typed, DIR_ROWS[k].want);
        // shorten the gap mid-frame; the running bit keeps the timing it started with
        program_timing(ppe_pkg::RST_ONE_HIGH, ppe_pkg::RST_ONE_LOW, ppe_pkg::RST_ZERO_HIGH,
                       ppe_pkg::RST_ZERO_LOW, SHORT_GAP);
        finish_frame();

        // zero durations count as one tick
        program_timing('0, '0, '0, '0, '0);
        send_item(1'b1, 8'hFF, 8'hFF, 8'hFF);
        finish_frame();
        send_item(1'b1, 8'h00, 8'h00, 8'h00);
        finish_frame();

        for (int p = 0; p < RAND_PHASES; p++) begin
            quiet = (p % 4 == 3);
            program_timing(short_ticks(), short_ticks(), short_ticks(), short_ticks(),
                           short_ticks());
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == 50)
                    hold_req = 1'b1;
                if (p == 5 && k == 100) begin
                    i_in_valid <= 1'b0;
                    wait (pulse_q.size() == 0);
                    @(posedge i_clk);
                end
                // mostly start soon when idle, rarely a stray start mid-frame
                if (phase_now == ppe_pkg::PH_IDLE)
                    start = ($urandom_range(0, 2) != 0);
                else
                    start = ($urandom_range(0, 15) == 0);
                send_item(start, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end

        i_in_valid <= 1'b0;
        wait (pulse_q.size() == 0);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial begin
        int stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                // hold off long enough for the input side to back up
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stall = quiet ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : result_check
        ppe_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pulse_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, expected none, got 0x%0h",
                             $time, {o_line_level, o_busy_res, o_frame_done,
                                     o_start_ignored, o_frames_sent});
            end else begin
                want = pulse_q.pop_front();
                check_field("line_level", 32'(want.line_level), 32'(o_line_level));
                check_field("busy_res", 32'(want.busy), 32'(o_busy_res));
                check_field("frame_done", 32'(want.frame_done), 32'(o_frame_done));
                check_field("start_ignored", 32'(want.start_ignored), 32'(o_start_ignored));
                check_field("frames_sent", want.frames_sent, o_frames_sent);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

endmodule
